// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// checks made with the usual form are sampled on clk and suspended while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic form with explicit clock and reset
`define ASSERT_AT(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// usual form for modules with clk and arst_n ports
`define ASSERT_DEF(label, prop, msg) \
	`ASSERT_AT(label, clk, arst_n, prop, msg)

`endif

// ===== hw/rtl/tea_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// shared types, constants and round-sum helpers for the tea cipher engine
// ----------------------------------------------------------------------------
package tea_pkg;

	typedef logic [31:0] word_t;

	localparam int unsigned ROUNDS = 32;
	// one cell per half-round
	localparam int unsigned STAGES = 2 * ROUNDS;

	localparam word_t DELTA = 32'h9e37_79b9;

	// built-in key after reset
	localparam word_t KEY_DEFAULT0 = 32'd307707552;
	localparam word_t KEY_DEFAULT1 = 32'd421327355;
	localparam word_t KEY_DEFAULT2 = 32'd199322388;
	localparam word_t KEY_DEFAULT3 = 32'd356690258;

	// register indexes on the configuration port
	localparam int unsigned KEY_IDX_W = 2;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_0 = 2'd0;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_1 = 2'd1;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_2 = 2'd2;
	localparam logic [KEY_IDX_W-1:0] KEY_IDX_3 = 2'd3;

	// action codes
	localparam logic ACT_ENCRYPT = 1'b0;
	localparam logic ACT_DECRYPT = 1'b1;

	typedef struct packed {
		word_t k0;
		word_t k1;
		word_t k2;
		word_t k3;
	} tea_key_t;

	typedef struct packed {
		logic  valid;
		logic  action;
		word_t first;
		word_t second;
	} tea_item_t;

	// running sum seen by round r when encrypting: delta * (r + 1)
	function automatic word_t enc_sum(input int unsigned r);
		logic [63:0] prod;
		prod = 64'(DELTA) * 64'(r + 1);
		return prod[31:0];
	endfunction

	// running sum seen by round r when decrypting: delta * (rounds - r)
	function automatic word_t dec_sum(input int unsigned r);
		logic [63:0] prod;
		prod = 64'(DELTA) * 64'(ROUNDS - r);
		return prod[31:0];
	endfunction

endpackage

// ===== hw/rtl/tea_key_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_key_regs
// four 32-bit key registers, reset to the built-in key, write-only port
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_key_regs
	import tea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [KEY_IDX_W-1:0] cfg_index,
	input  word_t                cfg_wdata,
	output tea_key_t             key
);

	tea_key_t key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k0 <= KEY_DEFAULT0;
			key_q.k1 <= KEY_DEFAULT1;
			key_q.k2 <= KEY_DEFAULT2;
			key_q.k3 <= KEY_DEFAULT3;
		end else if (cfg_we) begin
			unique case (cfg_index)
				KEY_IDX_0: key_q.k0 <= cfg_wdata;
				KEY_IDX_1: key_q.k1 <= cfg_wdata;
				KEY_IDX_2: key_q.k2 <= cfg_wdata;
				KEY_IDX_3: key_q.k3 <= cfg_wdata;
			endcase
		end
	end

	assign key = key_q;

	`ASSERT_DEF(a_key3_write, cfg_we && (cfg_index == KEY_IDX_3) |=> key_q.k3 == $past(cfg_wdata), "key word 3 write lost")

endmodule

// ===== hw/rtl/tea_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_cell
// one registered half-round of tea, works in either direction
// ----------------------------------------------------------------------------
module tea_cell
	import tea_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  logic      half,
	input  word_t     sum_enc,
	input  word_t     sum_dec,
	input  tea_key_t  key,
	input  tea_item_t item_in,
	output tea_item_t item_out
);

	logic  upd_first;
	word_t x;
	word_t ka;
	word_t kb;
	word_t sum;
	word_t mix;
	word_t target;
	word_t result;

	logic  valid_q;
	logic  action_q;
	word_t first_q;
	word_t second_q;

	// encrypt: first half updates the first word, decrypt: second half does
	assign upd_first = (half == item_in.action);
	assign x         = upd_first ? item_in.second : item_in.first;
	assign ka        = upd_first ? key.k0 : key.k2;
	assign kb        = upd_first ? key.k1 : key.k3;
	assign sum       = (item_in.action == ACT_DECRYPT) ? sum_dec : sum_enc;
	assign mix       = ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
	assign target    = upd_first ? item_in.first : item_in.second;
	assign result    = (item_in.action == ACT_DECRYPT) ? target - mix : target + mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_q <= item_in.action;
			first_q  <= upd_first ? result : item_in.first;
			second_q <= upd_first ? item_in.second : result;
		end
	end

	assign item_out.valid  = valid_q;
	assign item_out.action = action_q;
	assign item_out.first  = first_q;
	assign item_out.second = second_q;

endmodule

// ===== hw/rtl/tea_block_cipher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher
// pipelined tiny encryption algorithm engine, 32 rounds, encrypt or decrypt
// ----------------------------------------------------------------------------
// One 64-bit block enters per clock while the output is not stalled, as two
// 32-bit words with an action bit in tuser (0 encrypt, 1 decrypt), and leaves
// transformed with the 128-bit key held in four write-only registers (built-in
// key after reset). The engine is a row of 64 identical half-round cells, two
// per round, each a pipeline stage; the last cell is the output register.
// Sustained rate is one transaction per cycle. When the output transaction is
// stalled the whole row holds, and s_tready falls only then; bubbles in the
// row are not collapsed, they travel with it, and an empty output cell never
// holds the row. Key writes are meant for idle times.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tea_block_cipher
	import tea_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// input block stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [63:0]          s_tdata,   // [31:0] block_first, [63:32] block_second
	input  logic                 s_tuser,   // [0] action
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [63:0]          m_tdata,   // [31:0] out_first, [63:32] out_second
	// key configuration
	input  logic                 cfg_we,
	input  logic [KEY_IDX_W-1:0] cfg_index,
	input  word_t                cfg_wdata
);

	tea_key_t          key;
	tea_item_t         stage_item [0:STAGES];
	logic [STAGES-1:0] valid_vec;
	logic              advance;

	// key registers
	tea_key_regs u_keys (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.key       (key)
	);

	// the whole row moves unless a finished result is still waiting
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = advance;

	// incoming transaction feeds the first cell
	assign stage_item[0].valid  = s_tvalid;
	assign stage_item[0].action = s_tuser;
	assign stage_item[0].first  = s_tdata[31:0];
	assign stage_item[0].second = s_tdata[63:32];

	// row of half-round cells, the round sum of each is fixed at elaboration
	for (genvar h = 0; h < STAGES; h++) begin : g_cell
		localparam int unsigned RND  = h / 2;
		localparam logic        HALF = 1'(h % 2);
		localparam word_t       SUM_E = enc_sum(RND);
		localparam word_t       SUM_D = dec_sum(RND);

		tea_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.half     (HALF),
			.sum_enc  (SUM_E),
			.sum_dec  (SUM_D),
			.key      (key),
			.item_in  (stage_item[h]),
			.item_out (stage_item[h+1])
		);

		assign valid_vec[h] = stage_item[h+1].valid;
	end

	// last cell register doubles as the output register
	assign m_tvalid = stage_item[STAGES].valid;
	assign m_tdata  = {stage_item[STAGES].second, stage_item[STAGES].first};

	// stalled row keeps every occupied slot in place
	`ASSERT_DEF(a_stall_holds, !advance |=> $stable(valid_vec), "pipeline moved while stalled")
	// moving row shifts occupancy by exactly one cell
	`ASSERT_DEF(a_row_shifts, advance |=> valid_vec[STAGES-1:1] == $past(valid_vec[STAGES-2:0]), "pipeline occupancy did not shift")
	// accepted transaction lands in the first cell
	`ASSERT_DEF(a_accept_lands, s_tvalid && s_tready |=> valid_vec[0], "accepted block dropped")

endmodule
